// ===== rtl/pr2d_pkg.sv =====
`timescale 1ns / 1ps

package pr2d_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 32;
    localparam int PT_W              = 32;
    localparam int ANGLE_W           = 16;
    localparam int GUARD_BITS        = 16;
    localparam int K_FRAC            = 30;
    localparam int K_W               = 30;
    localparam int PROD_W            = PT_W + K_W + 1;
    localparam int PRE_SHIFT         = K_FRAC - GUARD_BITS;
    localparam int DATA_W            = 50;
    localparam int Z_W               = 32;
    localparam int ATAN_W            = 30;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } t_vec;

    // Angle steps atan(2^-i) in units of 2^-32 turn.
    localparam logic [ATAN_W-1:0] ATAN_TURN32 [MAX_STAGES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // Gain compensation in Q0.30 for n iterations, evaluated at elaboration.
    function automatic logic [K_W-1:0] gain_q30(input int n);
        logic [63:0] g2;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] num;
        g2  = 64'd1 << 60;
        for (int i = 0; i < n; i++) begin
            g2 = g2 + (g2 >> (2 * i));
        end
        v   = g2;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        if (res == '0) begin
            res = 64'd1;
        end
        num = 64'd1 << 60;
        rem = '0;
        quo = '0;
        for (int j = 60; j >= 0; j--) begin
            rem = {rem[62:0], num[j]};
            if (rem >= res) begin
                rem    = rem - res;
                quo[j] = 1'b1;
            end
        end
        return quo[K_W-1:0];
    endfunction

endpackage

// ===== rtl/pr2d_if.sv =====
`timescale 1ns / 1ps

interface pr2d_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [pr2d_pkg::PT_W-1:0] x_in;
    logic signed [pr2d_pkg::PT_W-1:0] y_in;
    modport source (output valid, output x_in, output y_in, input ready);
    modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

interface pr2d_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [pr2d_pkg::PT_W-1:0] x_out;
    logic signed [pr2d_pkg::PT_W-1:0] y_out;
    modport source (output valid, output x_out, output y_out, input ready);
    modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

interface pr2d_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pr2d_pkg::ANGLE_W-1:0]       rotate_angle;
    modport source (output valid, output rotate_angle, input ready);
    modport sink   (input valid, input rotate_angle, output ready);
endinterface

// ===== rtl/pr2d_cordic_stage.sv =====
`timescale 1ns / 1ps

module pr2d_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  pr2d_pkg::t_vec     i_vec,
    output logic               o_valid,
    output pr2d_pkg::t_vec     o_vec
);

    localparam logic signed [pr2d_pkg::Z_W-1:0] ATAN =
        $signed({{(pr2d_pkg::Z_W-pr2d_pkg::ATAN_W){1'b0}}, pr2d_pkg::ATAN_TURN32[STAGE]});

    logic                 r_valid;
    pr2d_pkg::t_vec       r_vec;
    pr2d_pkg::t_vec       n_vec;
    logic signed [pr2d_pkg::DATA_W-1:0] dx;
    logic signed [pr2d_pkg::DATA_W-1:0] dy;

    assign dx = i_vec.y >>> STAGE;
    assign dy = i_vec.x >>> STAGE;

    // Residual angle sign picks the rotation direction.
    always_comb begin
        if (!i_vec.z[pr2d_pkg::Z_W-1]) begin
            n_vec.x = i_vec.x - dx;
            n_vec.y = i_vec.y + dy;
            n_vec.z = i_vec.z - ATAN;
        end else begin
            n_vec.x = i_vec.x + dx;
            n_vec.y = i_vec.y - dy;
            n_vec.z = i_vec.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// ===== rtl/point_rotation_2d.sv =====
`timescale 1ns / 1ps

// Rotates a Q16.16 point (x_in, y_in) clockwise by rotate_angle, a fraction
// of a full turn where 65536 is one turn, and saturates the result to Q16.16.
// Input items arrive on i_pt and results leave on o_pt; both are valid/ready
// channels and an item moves when valid and ready are high at a clock edge.
// The angle is written through i_cfg, which is always ready; write it only
// while no item is in flight.
// The datapath is a pipeline of registers: gain multiply, quarter-turn
// pre-rotation, one CORDIC iteration per stage, then rounding and
// saturation, followed by the output register. One item is accepted every
// cycle while i_pt.ready is high, set by the single iteration in each stage.
// When the receiver stalls, a skid register catches the item leaving the
// pipeline; i_pt.ready drops only while that skid register is occupied, and
// the pipeline then holds still without losing or repeating items.
// Reset (synchronous, active low) empties the pipeline and sets the angle
// to zero.
module point_rotation_2d #(
    parameter int CORDIC_STAGES = pr2d_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pr2d_in_if.sink      i_pt,
    pr2d_out_if.source   o_pt,
    pr2d_cfg_if.sink     i_cfg
);

    localparam logic [pr2d_pkg::K_W-1:0] GAIN = pr2d_pkg::gain_q30(CORDIC_STAGES);
    localparam int DW = pr2d_pkg::DATA_W;
    localparam int PW = pr2d_pkg::PROD_W;
    localparam int SW = PW - pr2d_pkg::PRE_SHIFT;
    localparam int RW = DW - pr2d_pkg::GUARD_BITS;
    localparam int OW = pr2d_pkg::PT_W;

    logic [pr2d_pkg::ANGLE_W-1:0] r_angle;

    logic en;
    logic take;
    logic leave;

    // Multiply stage.
    logic                          r_mv;
    logic signed [PW-1:0]          r_mx;
    logic signed [PW-1:0]          r_my;
    pr2d_pkg::t_quad               r_mq;
    logic signed [pr2d_pkg::ANGLE_W-1:0] r_mr;
    logic [pr2d_pkg::ANGLE_W-1:0]  turn;
    logic [pr2d_pkg::ANGLE_W-1:0]  turn_ofs;
    logic [pr2d_pkg::ANGLE_W-1:0]  resid;

    // Pre-rotation stage.
    logic                          r_pv;
    pr2d_pkg::t_vec                r_pvec;
    pr2d_pkg::t_vec                n_pvec;
    logic signed [PW-1:0]          sel_x;
    logic signed [PW-1:0]          sel_y;

    // CORDIC chain.
    logic                          w_v   [CORDIC_STAGES+1];
    pr2d_pkg::t_vec                w_vec [CORDIC_STAGES+1];

    // Round stage.
    logic                          r_rv;
    logic signed [OW-1:0]          r_rx;
    logic signed [OW-1:0]          r_ry;

    // Output register and skid register.
    logic                          r_ov;
    logic signed [OW-1:0]          r_ox;
    logic signed [OW-1:0]          r_oy;
    logic                          r_sv;
    logic signed [OW-1:0]          r_sx;
    logic signed [OW-1:0]          r_sy;

    function automatic logic signed [OW-1:0] round_sat(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] sum;
        logic signed [RW-1:0] sh;
        sum = v + $signed({{(DW-pr2d_pkg::GUARD_BITS){1'b0}},
                           1'b1, {(pr2d_pkg::GUARD_BITS-1){1'b0}}});
        sh  = sum[DW-1:pr2d_pkg::GUARD_BITS];
        if (sh[RW-1:OW-1] == '0 || sh[RW-1:OW-1] == '1) begin
            return sh[OW-1:0];
        end else if (sh[RW-1]) begin
            return {1'b1, {(OW-1){1'b0}}};
        end else begin
            return {1'b0, {(OW-1){1'b1}}};
        end
    endfunction

    assign en          = !r_sv;
    assign take        = r_ov && o_pt.ready;
    assign leave       = en && r_rv;
    assign i_pt.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (i_cfg.valid) begin
            r_angle <= i_cfg.rotate_angle;
        end
    end

    // Counterclockwise phase split into a quarter turn and a residual
    // within plus or minus an eighth of a turn.
    assign turn     = -r_angle;
    assign turn_ofs = turn + {2'b00, 1'b1, {(pr2d_pkg::ANGLE_W-3){1'b0}}};
    assign resid    = turn - {turn_ofs[pr2d_pkg::ANGLE_W-1 -: 2],
                              {(pr2d_pkg::ANGLE_W-2){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx <= PW'(i_pt.x_in * $signed({1'b0, GAIN}));
            r_my <= PW'(i_pt.y_in * $signed({1'b0, GAIN}));
            r_mq <= pr2d_pkg::t_quad'(turn_ofs[pr2d_pkg::ANGLE_W-1 -: 2]);
            r_mr <= $signed(resid);
        end
    end

    // Negation happens on the full product so that the later shift floors
    // the same way as for a positive operand.
    always_comb begin
        unique case (r_mq)
            pr2d_pkg::QUAD_90: begin
                sel_x = -r_my;
                sel_y = r_mx;
            end
            pr2d_pkg::QUAD_180: begin
                sel_x = -r_mx;
                sel_y = -r_my;
            end
            pr2d_pkg::QUAD_270: begin
                sel_x = r_my;
                sel_y = -r_mx;
            end
            default: begin
                sel_x = r_mx;
                sel_y = r_my;
            end
        endcase
        n_pvec.x = $signed({{(DW-SW){sel_x[PW-1]}}, sel_x[PW-1:pr2d_pkg::PRE_SHIFT]});
        n_pvec.y = $signed({{(DW-SW){sel_y[PW-1]}}, sel_y[PW-1:pr2d_pkg::PRE_SHIFT]});
        n_pvec.z = $signed({r_mr, {(pr2d_pkg::Z_W-pr2d_pkg::ANGLE_W){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pvec <= n_pvec;
        end
    end

    assign w_v[0]   = r_pv;
    assign w_vec[0] = r_pvec;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        pr2d_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_v[g]),
            .i_vec   (w_vec[g]),
            .o_valid (w_v[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (en) begin
            r_rv <= w_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx <= round_sat(w_vec[CORDIC_STAGES].x);
            r_ry <= round_sat(w_vec[CORDIC_STAGES].y);
        end
    end

    // The output register holds the older item; the skid register the newer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (take || !r_ov) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= leave;
            end
        end else if (leave) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_ov) begin
            if (r_sv) begin
                r_ox <= r_sx;
                r_oy <= r_sy;
            end else begin
                r_ox <= r_rx;
                r_oy <= r_ry;
            end
        end else if (leave) begin
            r_sx <= r_rx;
            r_sy <= r_ry;
        end
    end

    assign o_pt.valid = r_ov;
    assign o_pt.x_out = r_ox;
    assign o_pt.y_out = r_oy;

endmodule

// ===== rtl/pr2d_chk.sv =====
`timescale 1ns / 1ps

module pr2d_chk #(
    parameter int STAGES = pr2d_pkg::CORDIC_STAGES_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [pr2d_pkg::PT_W-1:0] i_out_x,
    input logic [pr2d_pkg::PT_W-1:0] i_out_y
);

    localparam int CAP   = STAGES + 5;
    localparam int CNT_W = $clog2(CAP + 2);

    logic             in_take;
    logic             out_take;
    logic [CNT_W-1:0] r_cnt;

    assign in_take  = i_in_valid && i_in_ready;
    assign out_take = i_out_valid && i_out_ready;

    // Items accepted whose results have not left yet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_take && !out_take) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (out_take && !in_take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take |-> (r_cnt != '0))
        else $error("result delivered with no item outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAP))
        else $error("more items outstanding than the pipeline holds");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_x) && $stable(i_out_y)))
        else $error("output payload changed while stalled");

endmodule

bind point_rotation_2d pr2d_chk #(
    .STAGES (CORDIC_STAGES)
) u_pr2d_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_out_x     (o_pt.x_out),
    .i_out_y     (o_pt.y_out)
);

// ===== test/tb_point_rotation_2d.sv =====
`timescale 1ns / 1ps

module tb_point_rotation_2d;

    localparam int STAGES      = 16;
    localparam int GUARD       = 16;
    localparam int LATENCY     = STAGES + 4;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [31:0] PT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PT_MIN = 32'sh8000_0000;

    // atan(2^-i) in units of 2^-32 turn.
    localparam longint ATAN_STEP [STAGES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_point;

    logic clk;
    logic rst_n;

    pr2d_in_if  pt_in();
    pr2d_out_if pt_out();
    pr2d_cfg_if cfg();

    point_rotation_2d #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pt    (pt_in),
        .o_pt    (pt_out),
        .i_cfg   (cfg)
    );

    t_point      rotated_q[$];
    logic [15:0] cur_angle;
    longint      gain_k;
    int          send_idle_pct;
    int          stall_pct;
    int          mismatch_cnt;
    int          cycle_cnt;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gain compensation 1/sqrt(prod(1 + 4^-i)) in Q0.30.
    function automatic longint rotation_gain(int n);
        logic [63:0] g2;
        logic [63:0] root;
        logic [63:0] cand;
        g2 = 64'd1 << 60;
        for (int i = 0; i < n; i++) begin
            g2 = g2 + (g2 >> (2 * i));
        end
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= g2) begin
                root = cand;
            end
        end
        if (root == '0) begin
            root = 64'd1;
        end
        return longint'((64'd1 << 60) / root);
    endfunction

    function automatic logic signed [31:0] round_sat(longint v);
        longint r;
        r = (v + (longint'(1) << (GUARD - 1))) >>> GUARD;
        if (r > PT_MAX) begin
            return PT_MAX;
        end
        if (r < PT_MIN) begin
            return PT_MIN;
        end
        return r[31:0];
    endfunction

    function automatic t_point predict_rotation(logic [15:0] ang, t_point p);
        logic [15:0]        t;
        logic signed [15:0] resid;
        pr2d_pkg::t_quad    quad;
        longint             px;
        longint             py;
        longint             nx;
        longint             dx;
        longint             dy;
        longint             z;
        t_point             res;
        // Clockwise rotation is a counterclockwise one by the negated phase.
        t     = 16'd0 - ang;
        quad  = pr2d_pkg::t_quad'(2'(({1'b0, t} + 17'd8192) >> 14));
        resid = t - {quad, 14'd0};
        case (quad)
            pr2d_pkg::QUAD_90: begin
                px = -longint'(p.y);
                py = longint'(p.x);
            end
            pr2d_pkg::QUAD_180: begin
                px = -longint'(p.x);
                py = -longint'(p.y);
            end
            pr2d_pkg::QUAD_270: begin
                px = longint'(p.y);
                py = -longint'(p.x);
            end
            default: begin
                px = longint'(p.x);
                py = longint'(p.y);
            end
        endcase
        px = (px * gain_k) >>> (30 - GUARD);
        py = (py * gain_k) >>> (30 - GUARD);
        z  = longint'(resid) * 65536;
        for (int i = 0; i < STAGES; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (z >= 0) begin
                nx = px - dx;
                py = py + dy;
                z  = z - ATAN_STEP[i];
            end else begin
                nx = px + dx;
                py = py - dy;
                z  = z + ATAN_STEP[i];
            end
            px = nx;
        end
        res.x = round_sat(px);
        res.y = round_sat(py);
        return res;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(2097152) - 1048576;
            7:          return PT_MAX - $urandom_range(255);
            8:          return PT_MIN + $urandom_range(255);
            default:    return $urandom_range(2) - 1;
        endcase
    endfunction

    always @(posedge clk) begin
        pt_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        t_point want;
        if (rst_n && pt_out.valid && pt_out.ready) begin
            if (rotated_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result x=%0d y=%0d",
                                        pt_out.x_out, pt_out.y_out));
            end else begin
                want = rotated_q.pop_front();
                if (want.x !== pt_out.x_out) begin
                    flag_mismatch($sformatf("x_out mismatch: expected %0d, got %0d",
                                            want.x, pt_out.x_out));
                end
                if (want.y !== pt_out.y_out) begin
                    flag_mismatch($sformatf("y_out mismatch: expected %0d, got %0d",
                                            want.y, pt_out.y_out));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[point_rotation_2d] ERROR");
            $finish;
        end
    end

    // Leaves the input channel idle until every pending item has come out.
    task automatic settle();
        pt_in.valid <= 1'b0;
        while (rotated_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_angle(logic [15:0] ang);
        settle();
        cfg.valid        <= 1'b1;
        cfg.rotate_angle <= ang;
        do @(posedge clk); while (!cfg.ready);
        cur_angle = ang;
        cfg.valid <= 1'b0;
    endtask

    task automatic send_point(t_point p);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_in.valid <= 1'b0;
            @(posedge clk);
        end
        pt_in.valid <= 1'b1;
        pt_in.x_in  <= p.x;
        pt_in.y_in  <= p.y;
        do @(posedge clk); while (!pt_in.ready);
        rotated_q = {rotated_q, predict_rotation(cur_angle, p)};
    endtask

    // Runs at the reset angle of zero: origin, points one LSB off it and the corners.
    task automatic test_reset_angle();
        t_point pts[7] = '{
            '{32'sd0, 32'sd0}, '{32'sd1, 32'sd0}, '{32'sd0, -32'sd1},
            '{PT_MAX, PT_MAX}, '{PT_MIN, PT_MIN}, '{PT_MAX, PT_MIN},
            '{PT_MIN, PT_MAX}
        };
        foreach (pts[i]) begin
            send_point(pts[i]);
        end
    endtask

    // Every quarter-turn case, both sides of the quadrant boundary, and
    // full-scale points, which can saturate when rotated.
    task automatic test_quadrants();
        logic [15:0] angles[6] = '{
            16'd8192, 16'd57344, 16'd57345, 16'd32768, 16'd16384, 16'hFFFF
        };
        t_point pts[3] = '{
            '{PT_MAX, PT_MAX}, '{PT_MIN, 32'sd65536}, '{32'sd0, PT_MIN}
        };
        foreach (angles[a]) begin
            write_angle(angles[a]);
            foreach (pts[i]) begin
                send_point(pts[i]);
            end
        end
    endtask

    task automatic test_random(int n, int idle, int stall, logic [15:0] ang);
        t_point p;
        write_angle(ang);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n) begin
            p.x = random_coord();
            p.y = random_coord();
            send_point(p);
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        pt_in.valid      = 1'b0;
        pt_in.x_in       = '0;
        pt_in.y_in       = '0;
        pt_out.ready     = 1'b0;
        cfg.valid        = 1'b0;
        cfg.rotate_angle = '0;
        cur_angle        = '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        mismatch_cnt     = 0;
        cycle_cnt        = 0;
        gain_k           = rotation_gain(STAGES);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_angle();
        test_quadrants();
        test_random(250, 0, 0, 16'd0);
        test_random(250, 47, 0, 16'hFFFF);
        test_random(250, 0, 47, 16'($urandom_range(65535)));
        test_random(250, 31, 31, 16'($urandom_range(65535)));
        test_random(250, 0, 0, 16'($urandom_range(65535)));
        test_random(250, 47, 0, 16'($urandom_range(65535)));
        test_random(250, 0, 47, 16'd8192);
        test_random(250, 31, 31, 16'($urandom_range(65535)));

        settle();
        if (mismatch_cnt == 0 && rotated_q.size() == 0) begin
            $display("[point_rotation_2d] OK");
        end else begin
            $display("[point_rotation_2d] ERROR");
        end
        $finish;
    end

endmodule
